### design/twct_pkg.sv
package twct_pkg;

	localparam int CACHE_ENTRIES = 32;
	localparam int IDX_W         = $clog2(CACHE_ENTRIES);
	localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
	localparam int LIM_W         = (CNT_W > 6) ? CNT_W : 6;

	localparam logic [5:0] LIMIT_RESET = 6'd32;
	localparam logic [1:0] MODE_DIRECT = 2'd2;

	localparam logic CFG_WINDOW_LIMIT = 1'b0;
	localparam logic CFG_TALL_VRAM    = 1'b1;

	localparam logic OP_LOOKUP     = 1'b0;
	localparam logic OP_INVALIDATE = 1'b1;

	typedef struct packed {
		logic [31:0] pos;
		logic [5:0]  page;
		logic [1:0]  mode;
		logic [30:0] key;
	} tag_t;

	typedef struct packed {
		logic [5:0] lo1;
		logic [5:0] hi1;
		logic [5:0] lo2;
		logic [5:0] hi2;
	} page_range_t;

	typedef struct packed {
		logic tag_eq;
		logic in_range;
	} match_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ALLOC
	} state_t;

endpackage

### design/twct_prep.sv
module twct_prep import twct_pkg::*; (
	input  logic               tall_vram,
	input  logic [5:0]         page_id,
	input  logic [1:0]         texture_mode,
	input  logic [15:0]        palette_id,
	input  logic               semi_transparent,
	input  logic [13:0]        palette_hash,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic signed [11:0] size_w,
	input  logic signed [11:0] size_h,
	output tag_t               tag,
	output page_range_t        range
);

	function automatic logic [9:0] clamp_hi(input logic signed [13:0] v, input logic [9:0] hi);
		logic [9:0] r;
		if (v < 14'sd0) begin
			r = 10'd0;
		end else if (v > $signed({4'b0000, hi})) begin
			r = hi;
		end else begin
			r = v[9:0];
		end
		return r;
	endfunction

	logic signed [13:0] x_s, y_s, x2_s, y2_s;
	logic [9:0]         hmask;
	logic [1:0]         ymax;
	logic [9:0]         x_c, y_c;
	logic [10:0]        x2_c, y2_c;
	logic [1:0]         r1, r2;
	logic [2:0]         r2_raw;
	logic [3:0]         c1, c2;

	always_comb begin
		tag.pos  = {pos_x[7:0], size_w[7:0], pos_y[7:0], size_h[7:0]};
		tag.page = page_id;
		tag.mode = texture_mode;
		if (texture_mode == MODE_DIRECT) begin
			tag.key = '0;
		end else begin
			tag.key = {semi_transparent, palette_hash, 1'b0, palette_id[14:0]};
		end
	end

	always_comb begin
		x_s   = {{2{pos_x[11]}}, pos_x};
		y_s   = {{2{pos_y[11]}}, pos_y};
		x2_s  = x_s + {{2{size_w[11]}}, size_w} - 14'sd1;
		y2_s  = y_s + {{2{size_h[11]}}, size_h} - 14'sd1;
		hmask = tall_vram ? 10'd1023 : 10'd511;
		ymax  = tall_vram ? 2'd3 : 2'd1;

		x_c  = clamp_hi(x_s, 10'd1023);
		x2_c = {1'b0, clamp_hi(x2_s, 10'd1023)} + 11'd1;
		y_c  = clamp_hi(y_s, hmask);
		y2_c = {1'b0, clamp_hi(y2_s, hmask)} + 11'd1;

		r1     = (y_c[9:8] > ymax) ? ymax : y_c[9:8];
		r2_raw = y2_c[10:8];
		r2     = (r2_raw > {1'b0, ymax}) ? ymax : r2_raw[1:0];
		c1     = x_c[9:6];
		c2     = (x2_c[10:6] > 5'd15) ? 4'd15 : x2_c[9:6];

		if (r1 == r2) begin
			range.lo1 = {r1, c1};
			range.hi1 = {r1, c2};
			range.lo2 = {r1, c1};
			range.hi2 = {r1, c2};
		end else begin
			range.lo1 = {2'b00, c1};
			range.hi1 = {2'b00, c2};
			range.lo2 = {2'b01, c1};
			range.hi2 = {2'b01, c2};
		end
	end

endmodule

### design/twct_match.sv
module twct_match import twct_pkg::*; (
	input  tag_t        stored,
	input  tag_t        lookup,
	input  page_range_t range,
	output match_t      result
);

	always_comb begin
		result.tag_eq   = (stored == lookup);
		result.in_range = ((stored.page >= range.lo1) && (stored.page <= range.hi1))
			|| ((stored.page >= range.lo2) && (stored.page <= range.hi2));
	end

endmodule

### design/texture_window_cache_tags.sv
// channel    | handshake                  | payload
// -----------+----------------------------+-------------------------------------------
// item in    | start & !busy              | operation, page_id, texture_mode, palette_id,
//            |                            | semi_transparent, palette_hash, pos/size
// result out | done (one cycle)           | hit, entry_index, needs_load, live_count
// config     | cfg_valid & cfg_ready      | cfg_index, cfg_data
//
// The tag RAM is scanned one entry per cycle over the entries below live_count.
// A hit ends the scan at the matching entry; an invalidate scans every such entry; a miss
// scans every such entry, then allocates a slot. done marks the result in the first cycle with busy low;
// the receiver cannot stall it, and a new start is taken in that same cycle.
// arst_n clears valid bits, the used count, the replacement pointer and config; tag RAM contents are not reset.
module texture_window_cache_tags import twct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [5:0]         page_id,
	input  logic [1:0]         texture_mode,
	input  logic [15:0]        palette_id,
	input  logic               semi_transparent,
	input  logic [13:0]        palette_hash,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic signed [11:0] size_w,
	input  logic signed [11:0] size_h,
	output logic               done,
	output logic               hit,
	output logic [4:0]         entry_index,
	output logic               needs_load,
	output logic [5:0]         live_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [5:0]         cfg_data
);

	state_t state_q, state_nxt;

	logic [5:0]  limit_q;
	logic        tall_q;

	tag_t        lookup_tag_q, prep_tag, rd_tag_s1;
	page_range_t range_q, prep_range;
	match_t      match;
	logic        op_q;

	tag_t        tag_mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;

	logic [CNT_W-1:0] rd_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] last_live_q;
	logic [IDX_W-1:0] rp_q;
	logic [IDX_W-1:0] free_q;
	logic             have_free_q;

	logic             done_q, hit_q, load_q;
	logic [4:0]       index_q;
	logic [5:0]       live_q;

	logic             accept, issuing, entry_live, scan_hit, scan_end;
	logic [LIM_W-1:0] lim, used_ext, rp_ext, rr_slot, rr_inc;
	logic             full;
	logic [IDX_W-1:0] alloc_slot, rr_next;
	logic [CNT_W-1:0] new_used;

	twct_prep u_prep (
		.tall_vram       (tall_q),
		.page_id         (page_id),
		.texture_mode    (texture_mode),
		.palette_id      (palette_id),
		.semi_transparent(semi_transparent),
		.palette_hash    (palette_hash),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.size_w          (size_w),
		.size_h          (size_h),
		.tag             (prep_tag),
		.range           (prep_range)
	);

	twct_match u_match (
		.stored(rd_tag_s1),
		.lookup(lookup_tag_q),
		.range (range_q),
		.result(match)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			tall_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW_LIMIT: limit_q <= cfg_data;
				CFG_TALL_VRAM:    tall_q  <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_hit) begin
					state_nxt = ST_IDLE;
				end else if (scan_end) begin
					state_nxt = (op_q == OP_INVALIDATE) ? ST_IDLE : ST_ALLOC;
				end
			end
			ST_ALLOC: state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// state decode
	always_comb begin
		busy    = 1'b1;
		issuing = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_SCAN:  issuing = (rd_idx_q < used_q);
			ST_ALLOC: ;
			default:  ;
		endcase
		accept     = start && !busy;
		entry_live = cmp_vld_s1 && valid_q[cmp_idx_s1];
		scan_hit   = (state_q == ST_SCAN) && entry_live && match.tag_eq && (op_q == OP_LOOKUP);
		scan_end   = (state_q == ST_SCAN) && !issuing && !cmp_vld_s1;
	end

	// slot choice on a miss
	always_comb begin
		if (limit_q == 6'd0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(limit_q) > LIM_W'(CACHE_ENTRIES)) begin
			lim = LIM_W'(CACHE_ENTRIES);
		end else begin
			lim = LIM_W'(limit_q);
		end
		used_ext = LIM_W'(used_q);
		rp_ext   = LIM_W'(rp_q);
		full     = (used_ext >= lim) || (used_ext >= LIM_W'(CACHE_ENTRIES));
		rr_slot  = (rp_ext < lim) ? rp_ext : '0;
		rr_inc   = rr_slot + LIM_W'(1);
		rr_next  = (rr_inc >= lim) ? '0 : rr_inc[IDX_W-1:0];
		new_used = used_q;
		if (have_free_q) begin
			alloc_slot = free_q;
		end else if (full) begin
			alloc_slot = rr_slot[IDX_W-1:0];
		end else begin
			alloc_slot = used_q[IDX_W-1:0];
			new_used   = used_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmp_vld_s1 <= 1'b0;
			valid_q    <= '0;
			used_q     <= '0;
			rp_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			cmp_vld_s1 <= issuing && !scan_hit;
			done_q     <= scan_hit || (scan_end && (op_q == OP_INVALIDATE))
				|| (state_q == ST_ALLOC);
			if ((state_q == ST_SCAN) && cmp_vld_s1 && (op_q == OP_INVALIDATE)
				&& valid_q[cmp_idx_s1] && match.in_range) begin
				valid_q[cmp_idx_s1] <= 1'b0;
			end
			if (scan_end && (op_q == OP_INVALIDATE)) begin
				used_q <= last_live_q;
			end
			if (state_q == ST_ALLOC) begin
				valid_q[alloc_slot] <= 1'b1;
				used_q              <= new_used;
				if (!have_free_q && full) rp_q <= rr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lookup_tag_q <= prep_tag;
			range_q      <= prep_range;
			op_q         <= operation;
			rd_idx_q     <= '0;
			have_free_q  <= 1'b0;
			last_live_q  <= '0;
		end else if (issuing) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
		cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		rd_tag_s1  <= tag_mem[rd_idx_q[IDX_W-1:0]];
		if ((state_q == ST_SCAN) && cmp_vld_s1) begin
			if (!valid_q[cmp_idx_s1]) begin
				free_q      <= cmp_idx_s1;
				have_free_q <= 1'b1;
			end else if (!match.in_range) begin
				last_live_q <= CNT_W'(cmp_idx_s1) + CNT_W'(1);
			end
		end
		if (state_q == ST_ALLOC) begin
			tag_mem[alloc_slot] <= lookup_tag_q;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_hit) begin
			hit_q   <= 1'b1;
			index_q <= 5'(cmp_idx_s1);
			load_q  <= 1'b0;
			live_q  <= 6'(used_q);
		end else if (scan_end && (op_q == OP_INVALIDATE)) begin
			hit_q   <= 1'b0;
			index_q <= '0;
			load_q  <= 1'b0;
			live_q  <= 6'(last_live_q);
		end else if (state_q == ST_ALLOC) begin
			hit_q   <= 1'b0;
			index_q <= 5'(alloc_slot);
			load_q  <= 1'b1;
			live_q  <= 6'(new_used);
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign entry_index = index_q;
	assign needs_load  = load_q;
	assign live_count  = live_q;

endmodule

### dv/testbench.sv
module testbench import twct_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_PAL4 = 2'd0;
	localparam logic [1:0] MODE_PAL8 = 2'd1;
	localparam logic [1:0] MODE_ODD  = 2'd3;
	localparam int SETTLE      = 4;
	localparam int TAIL_CYCLES = 50;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 700;
	localparam int POOL_DEPTH  = 40;

	typedef enum logic [1:0] {
		ACT_ITEM,
		ACT_CFG,
		ACT_DRAIN
	} act_t;

	typedef struct packed {
		act_t               kind;
		logic [6:0]         gap_pct;
		logic               operation;
		logic [5:0]         page;
		logic [1:0]         mode;
		logic [15:0]        pal;
		logic               semi;
		logic [13:0]        hash;
		logic signed [11:0] px;
		logic signed [11:0] py;
		logic signed [11:0] sw;
		logic signed [11:0] sh;
		logic [0:0]         cfg_sel;
		logic [5:0]         cfg_val;
	} tex_req_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
		logic       load;
		logic [5:0] live;
	} lookup_outcome_t;

	logic               clk              = 1'b0;
	logic               arst_n           = 1'b0;
	logic               start            = 1'b0;
	logic               operation        = OP_LOOKUP;
	logic [5:0]         page_id          = '0;
	logic [1:0]         texture_mode     = '0;
	logic [15:0]        palette_id       = '0;
	logic               semi_transparent = 1'b0;
	logic [13:0]        palette_hash     = '0;
	logic signed [11:0] pos_x            = '0;
	logic signed [11:0] pos_y            = '0;
	logic signed [11:0] size_w           = '0;
	logic signed [11:0] size_h           = '0;
	logic               cfg_valid        = 1'b0;
	logic [0:0]         cfg_index        = CFG_WINDOW_LIMIT;
	logic [5:0]         cfg_data         = '0;
	logic               busy;
	logic               done;
	logic               hit;
	logic [4:0]         entry_index;
	logic               needs_load;
	logic [5:0]         live_count;
	logic               cfg_ready;

	texture_window_cache_tags u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.page_id          (page_id),
		.texture_mode     (texture_mode),
		.palette_id       (palette_id),
		.semi_transparent (semi_transparent),
		.palette_hash     (palette_hash),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.size_w           (size_w),
		.size_h           (size_h),
		.done             (done),
		.hit              (hit),
		.entry_index      (entry_index),
		.needs_load       (needs_load),
		.live_count       (live_count),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the tag store
	logic        mdl_valid [CACHE_ENTRIES] = '{default: 1'b0};
	logic [31:0] mdl_pos   [CACHE_ENTRIES];
	logic [5:0]  mdl_page  [CACHE_ENTRIES];
	logic [1:0]  mdl_mode  [CACHE_ENTRIES];
	logic [30:0] mdl_key   [CACHE_ENTRIES];
	int          mdl_used  = 0;
	int          mdl_rr    = 0;
	logic [5:0]  mdl_limit = LIMIT_RESET;
	logic        mdl_tall  = 1'b0;

	tex_req_t        item_q[$];
	tex_req_t        recent_q[$];
	lookup_outcome_t outcome_q[$];
	tex_req_t        cur_req = '0;
	tex_req_t        nxt_req;
	lookup_outcome_t want;
	logic [6:0]      gap_now = 7'd34;
	int              errors = 0;
	int              in_flight = 0;
	int              quiet = 0;
	int              cycle_count = 0;
	logic            accepted;
	logic            start_nx;
	logic            cfg_nx;

	function automatic int clamp_to(int v, int hi);
		if (v < 0)
			return 0;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic lookup_outcome_t tag_store_step(tex_req_t r);
		lookup_outcome_t res;
		logic [31:0]     posw;
		logic [30:0]     key;
		int              x, y, x2, y2, hmask, rmax, r1, r2, c1, c2;
		int              lo1, hi1, lo2, hi2, p, i, slot, lim;
		bit              have_free;
		res = '0;
		if (r.operation == OP_INVALIDATE) begin
			x = $signed(r.px);
			y = $signed(r.py);
			x2 = x + $signed(r.sw) - 1;
			y2 = y + $signed(r.sh) - 1;
			hmask = mdl_tall ? 1023 : 511;
			rmax = mdl_tall ? 3 : 1;
			x = clamp_to(x, 1023);
			x2 = clamp_to(x2, 1023) + 1;
			y = clamp_to(y, hmask);
			y2 = clamp_to(y2, hmask) + 1;
			r1 = (y >> 8 > rmax) ? rmax : y >> 8;
			r2 = (y2 >> 8 > rmax) ? rmax : y2 >> 8;
			c1 = x >> 6;
			c2 = (x2 >> 6 > 15) ? 15 : x2 >> 6;
			if (r1 == r2) begin
				lo1 = c1 + r1 * 16;
				hi1 = c2 + r1 * 16;
				lo2 = lo1;
				hi2 = hi1;
			end else begin
				lo1 = c1;
				hi1 = c2;
				lo2 = c1 + 16;
				hi2 = c2 + 16;
			end
			for (i = 0; i < mdl_used; i++) begin
				p = int'(mdl_page[i]);
				if (mdl_valid[i] && ((p >= lo1 && p <= hi1) || (p >= lo2 && p <= hi2)))
					mdl_valid[i] = 1'b0;
			end
			while (mdl_used > 0 && !mdl_valid[mdl_used - 1])
				mdl_used--;
			res.live = 6'(mdl_used);
			return res;
		end
		key = (r.mode == MODE_DIRECT) ? '0 : {r.semi, r.hash, 1'b0, r.pal[14:0]};
		posw = {r.px[7:0], r.sw[7:0], r.py[7:0], r.sh[7:0]};
		slot = 0;
		have_free = 1'b0;
		for (i = 0; i < mdl_used; i++) begin
			if (mdl_valid[i]) begin
				if (mdl_pos[i] == posw && mdl_page[i] == r.page && mdl_mode[i] == r.mode
						&& mdl_key[i] == key) begin
					res.hit = 1'b1;
					res.idx = 5'(i);
					res.live = 6'(mdl_used);
					return res;
				end
			end else begin
				slot = i;
				have_free = 1'b1;
			end
		end
		if (!have_free) begin
			lim = (mdl_limit == 0) ? 1 : (mdl_limit > CACHE_ENTRIES) ? CACHE_ENTRIES
				: int'(mdl_limit);
			if (mdl_used >= lim) begin
				slot = (mdl_rr < lim) ? mdl_rr : 0;
				mdl_rr = (slot + 1 >= lim) ? 0 : slot + 1;
			end else begin
				slot = mdl_used;
				mdl_used++;
			end
		end
		mdl_pos[slot] = posw;
		mdl_page[slot] = r.page;
		mdl_mode[slot] = r.mode;
		mdl_key[slot] = key;
		mdl_valid[slot] = 1'b1;
		res.idx = 5'(slot);
		res.load = 1'b1;
		res.live = 6'(mdl_used);
		return res;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(3071)) - 1024;
	endfunction

	task automatic push_req(tex_req_t r);
		r.gap_pct = gap_now;
		item_q.push_back(r);
		if (r.kind == ACT_ITEM && r.operation == OP_LOOKUP) begin
			recent_q.push_back(r);
			if (recent_q.size() > POOL_DEPTH)
				void'(recent_q.pop_front());
		end
	endtask

	task automatic push_lookup(logic [5:0] page, logic [1:0] mode, logic [15:0] pal,
			logic semi, logic [13:0] hash, int px, int py, int sw, int sh);
		tex_req_t r;
		r = '0;
		r.kind = ACT_ITEM;
		r.operation = OP_LOOKUP;
		r.page = page;
		r.mode = mode;
		r.pal = pal;
		r.semi = semi;
		r.hash = hash;
		r.px = px[11:0];
		r.py = py[11:0];
		r.sw = sw[11:0];
		r.sh = sh[11:0];
		push_req(r);
	endtask

	task automatic push_invalidate(int px, int py, int sw, int sh);
		tex_req_t r;
		r = '0;
		r.kind = ACT_ITEM;
		r.operation = OP_INVALIDATE;
		r.page = 6'($urandom_range(63));
		r.mode = 2'($urandom_range(3));
		r.pal = 16'($urandom_range(65535));
		r.semi = 1'($urandom_range(1));
		r.hash = 14'($urandom_range(16383));
		r.px = px[11:0];
		r.py = py[11:0];
		r.sw = sw[11:0];
		r.sh = sh[11:0];
		push_req(r);
	endtask

	task automatic push_cfg(logic [0:0] sel, logic [5:0] val);
		tex_req_t r;
		r = '0;
		r.kind = ACT_CFG;
		r.cfg_sel = sel;
		r.cfg_val = val;
		push_req(r);
	endtask

	task automatic push_drain();
		tex_req_t r;
		r = '0;
		r.kind = ACT_DRAIN;
		push_req(r);
	endtask

	// driver: issues transactions from item_q, predicts each accepted one
	always @(posedge clk) begin
		if (arst_n) begin
			accepted = start && !busy;
			start_nx = start && !accepted;
			cfg_nx = cfg_valid && !cfg_ready;
			if (accepted)
				outcome_q.push_back(tag_store_step(cur_req));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WINDOW_LIMIT)
					mdl_limit = cfg_data;
				else
					mdl_tall = cfg_data[0];
			end
			in_flight = in_flight + int'(accepted) - int'(done);
			quiet = (start_nx || cfg_nx || in_flight != 0) ? 0 : quiet + 1;
			if (!start_nx && !cfg_nx && item_q.size() != 0) begin
				nxt_req = item_q[0];
				case (nxt_req.kind)
					ACT_ITEM: begin
						if ($urandom_range(99) >= nxt_req.gap_pct) begin
							void'(item_q.pop_front());
							cur_req = nxt_req;
							start_nx = 1'b1;
							operation <= nxt_req.operation;
							page_id <= nxt_req.page;
							texture_mode <= nxt_req.mode;
							palette_id <= nxt_req.pal;
							semi_transparent <= nxt_req.semi;
							palette_hash <= nxt_req.hash;
							pos_x <= nxt_req.px;
							pos_y <= nxt_req.py;
							size_w <= nxt_req.sw;
							size_h <= nxt_req.sh;
						end
					end
					ACT_CFG: begin
						if (quiet >= SETTLE) begin
							void'(item_q.pop_front());
							cfg_nx = 1'b1;
							cfg_index <= nxt_req.cfg_sel;
							cfg_data <= nxt_req.cfg_val;
						end
					end
					default: begin
						if (in_flight == 0)
							void'(item_q.pop_front());
					end
				endcase
			end
			start <= start_nx;
			cfg_valid <= cfg_nx;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: hit=%0d idx=%0d load=%0d live=%0d",
						hit, entry_index, needs_load, live_count);
			end else begin
				want = outcome_q.pop_front();
				if (hit !== want.hit || entry_index !== want.idx || needs_load !== want.load
						|| live_count !== want.live) begin
					errors++;
					if (errors <= 10)
						$display("mismatch hit/idx/load/live: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
							want.hit, want.idx, want.load, want.live,
							hit, entry_index, needs_load, live_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int       n, k;
		int       seg_limit [7];
		tex_req_t r;
		seg_limit = '{3, 32, 1, 63, 0, 8, 20};
		seg_limit[6] = int'($urandom_range(31, 2));

		push_lookup(0, MODE_PAL4, 0, 0, 0, 0, 0, 0, 0);
		push_lookup(0, MODE_PAL4, 0, 0, 0, 0, 0, 0, 0);
		push_lookup(63, MODE_DIRECT, 16'hFFFF, 1, 14'h3FFF, -1, -1, -1, -1);
		push_lookup(63, MODE_DIRECT, 16'h0000, 0, 14'h0000, -1, -1, -1, -1);
		push_lookup(42, MODE_ODD, 16'hFFFF, 1, 14'h3FFF, 2047, -1024, -1024, 2047);
		push_lookup(42, MODE_ODD, 16'h7FFF, 1, 14'h3FFF, 2047, -1024, -1024, 2047);
		push_lookup(21, MODE_PAL8, 16'h5555, 0, 14'h2AAA, 85, 170, 255, 128);
		push_lookup(21, MODE_PAL4, 16'h5555, 0, 14'h2AAA, 85, 170, 255, 128);
		push_lookup(21, MODE_PAL8, 16'h5555, 1, 14'h2AAA, 85, 170, 255, 128);
		// empty column range, then a rectangle across two page rows
		push_invalidate(500, 0, -200, 100);
		push_invalidate(0, 200, 64, 100);
		push_lookup(5, MODE_PAL8, 16'h1234, 0, 14'h0F0F, 10, 20, 30, 40);
		push_invalidate(-1024, -1024, 2047, 2047);
		push_cfg(CFG_TALL_VRAM, 6'd1);
		push_lookup(50, MODE_PAL4, 16'h00FF, 0, 14'h0001, 1, 2, 3, 4);
		push_lookup(60, MODE_DIRECT, 16'hAAAA, 1, 14'h1555, 2046, 7, 1, 9);
		push_invalidate(0, 768, 1024, 256);
		push_cfg(CFG_WINDOW_LIMIT, 6'd2);
		for (k = 0; k < 5; k++)
			push_lookup(6'($urandom_range(63)), 2'($urandom_range(3)),
				16'($urandom_range(65535)), 1'($urandom_range(1)),
				14'($urandom_range(16383)), rand_coord(), rand_coord(),
				rand_coord(), rand_coord());

		for (n = 0; n < RAND_ITEMS; n++) begin
			gap_now = (n < RAND_ITEMS / 3) ? 7'd34 : (n < 2 * RAND_ITEMS / 3) ? 7'd65 : 7'd0;
			if (n % 100 == 0) begin
				push_cfg(CFG_WINDOW_LIMIT, 6'(seg_limit[n / 100]));
				push_cfg(CFG_TALL_VRAM, {5'($urandom_range(31)), 1'((n / 100) % 2)});
			end
			if (n % 100 == 50)
				push_drain();
			k = int'($urandom_range(99));
			if (k < 55 && recent_q.size() != 0) begin
				r = recent_q[$urandom_range(recent_q.size() - 1)];
				if ($urandom_range(4) == 0) begin
					case ($urandom_range(2))
						0: r.pal[15] = ~r.pal[15];
						1: r.page[$urandom_range(5)] = ~r.page[$urandom_range(5)];
						default: begin
							if (r.mode == MODE_DIRECT)
								r.pal = 16'($urandom_range(65535));
							else
								r.semi = ~r.semi;
						end
					endcase
				end
				push_req(r);
			end else if (k < 85) begin
				push_lookup(6'($urandom_range(63)), 2'($urandom_range(3)),
					16'($urandom_range(65535)), 1'($urandom_range(1)),
					14'($urandom_range(16383)), rand_coord(), rand_coord(),
					rand_coord(), rand_coord());
			end else if (k < 95) begin
				push_invalidate(int'($urandom_range(1023)), int'($urandom_range(1023)),
					int'($urandom_range(400, 1)), int'($urandom_range(400, 1)));
			end else begin
				push_invalidate(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (item_q.size() != 0 || start || cfg_valid || in_flight != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (outcome_q.size() != 0) begin
			errors += outcome_q.size();
			$display("%0d results never arrived", outcome_q.size());
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
design/twct_pkg.sv
design/twct_prep.sv
design/twct_match.sv
design/texture_window_cache_tags.sv
dv/testbench.sv
